### design/tcw_pkg.sv
package tcw_pkg;

    // Field widths of the command and result beats
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int OFS_W  = 8;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;

    localparam logic [CHAR_W-1:0] NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK   = 8'h20;

    // Pointer home position on a full-size screen
    localparam int PTR_COL_HOME = 40;
    localparam int PTR_ROW_HOME = 12;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_WRITE = 2'd3
    } cmd_code_t;

    // Read address source
    typedef enum logic [1:0] {
        ADDR_ITEM  = 2'd0,
        ADDR_PTR   = 2'd1,
        ADDR_SWEEP = 2'd2
    } addr_sel_t;

    // Write data / address source
    typedef enum logic [2:0] {
        WR_ZERO  = 3'd0,
        WR_PUT   = 3'd1,
        WR_SWAP  = 3'd2,
        WR_BLANK = 3'd3,
        WR_HOST  = 3'd4
    } wr_op_t;

    typedef struct packed {
        logic      capture;
        logic      rd_en;
        addr_sel_t rd_sel;
        logic      wr_en;
        wr_op_t    wr_op;
        logic      text_adv;
        logic      ptr_move;
        logic      mark_clear;
        logic      sweep_clr;
        logic      sweep_inc;
        logic      load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_code_t command;
        logic      put_write;
        logic      need_clear;
        logic      host_ok;
        logic      sweep_last;
        logic      sweep_full;
        logic      out_free;
    } ctrl_stat_t;

    // 8-bit wrapping add of a signed offset, then clamp to [0, limit-1]
    function automatic logic [COL_W-1:0] move_axis(input logic [COL_W-1:0] pos,
                                                   input logic [OFS_W-1:0] off,
                                                   input logic [OFS_W-1:0] limit);
        logic [OFS_W-1:0] sum;
        logic [OFS_W-1:0] last;
        logic [COL_W-1:0] res;
        sum  = {1'b0, pos} + off;
        last = limit - 8'd1;
        if (sum[OFS_W-1])
            res = '0;
        else if (sum >= limit)
            res = last[COL_W-1:0];
        else
            res = sum[COL_W-1:0];
        return res;
    endfunction

endpackage

### design/tcw_cmd_if.sv
interface tcw_cmd_if import tcw_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [CHAR_W-1:0]        char_code;
    logic signed [OFS_W-1:0]  move_dx;
    logic signed [OFS_W-1:0]  move_dy;
    logic [IDX_W-1:0]         cell_index;
    logic [CELL_W-1:0]        cell_data;

    modport source (output valid, command, char_code, move_dx, move_dy, cell_index,
                    cell_data, input ready);
    modport sink   (input valid, command, char_code, move_dx, move_dy, cell_index,
                    cell_data, output ready);
endinterface

### design/tcw_res_if.sv
interface tcw_res_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] read_value;
    logic [COL_W-1:0]  out_text_col;
    logic [ROW_W-1:0]  out_text_row;
    logic [COL_W-1:0]  out_pointer_col;
    logic [ROW_W-1:0]  out_pointer_row;
    logic              screen_cleared;

    modport source (output valid, read_value, out_text_col, out_text_row, out_pointer_col,
                    out_pointer_row, screen_cleared, input ready);
    modport sink   (input valid, read_value, out_text_col, out_text_row, out_pointer_col,
                    out_pointer_row, screen_cleared, output ready);
endinterface

### design/tcw_ctrl.sv
module tcw_ctrl import tcw_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  ctl
);

    typedef enum logic [7:0] {
        ST_INIT     = 8'b0000_0001,
        ST_IDLE     = 8'b0000_0010,
        ST_EXEC     = 8'b0000_0100,
        ST_MOVE_RD  = 8'b0000_1000,
        ST_MOVE_WR  = 8'b0001_0000,
        ST_SWEEP_RD = 8'b0010_0000,
        ST_SWEEP    = 8'b0100_0000,
        ST_EMIT     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        logic finish;
        finish     = 1'b0;
        ctl        = '0;
        item_ready = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                // zero the store, one cell a cycle
                ctl.wr_en     = 1'b1;
                ctl.wr_op     = WR_ZERO;
                ctl.sweep_inc = 1'b1;
                if (stat.sweep_last)
                begin
                    ctl.sweep_clr = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    ctl.capture = 1'b1;
                    ctl.rd_en   = 1'b1;
                    ctl.rd_sel  = ADDR_ITEM;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (stat.command)
                    CMD_PUT:
                    begin
                        ctl.wr_en    = stat.put_write;
                        ctl.wr_op    = WR_PUT;
                        ctl.text_adv = 1'b1;
                        if (stat.need_clear)
                        begin
                            ctl.mark_clear = 1'b1;
                            ctl.sweep_clr  = 1'b1;
                            state_next     = ST_SWEEP_RD;
                        end
                        else
                            finish = 1'b1;
                    end
                    CMD_MOVE:
                    begin
                        ctl.wr_en    = 1'b1;
                        ctl.wr_op    = WR_SWAP;
                        ctl.ptr_move = 1'b1;
                        state_next   = ST_MOVE_RD;
                    end
                    CMD_WRITE:
                    begin
                        ctl.wr_en = stat.host_ok;
                        ctl.wr_op = WR_HOST;
                        finish    = 1'b1;
                    end
                    default:
                        finish = 1'b1;
                endcase
            end
            ST_MOVE_RD:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = ADDR_PTR;
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR:
            begin
                ctl.wr_en = 1'b1;
                ctl.wr_op = WR_SWAP;
                finish    = 1'b1;
            end
            ST_SWEEP_RD:
            begin
                ctl.rd_en     = 1'b1;
                ctl.rd_sel    = ADDR_SWEEP;
                ctl.sweep_inc = 1'b1;
                state_next    = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                // write back cell k-1 while reading cell k
                ctl.wr_en = 1'b1;
                ctl.wr_op = WR_BLANK;
                if (stat.sweep_full)
                    finish = 1'b1;
                else
                begin
                    ctl.rd_en     = 1'b1;
                    ctl.rd_sel    = ADDR_SWEEP;
                    ctl.sweep_inc = 1'b1;
                end
            end
            ST_EMIT:
                finish = 1'b1;
            default:
                state_next = ST_IDLE;
        endcase

        if (finish)
        begin
            if (stat.out_free)
            begin
                ctl.load_out = 1'b1;
                state_next   = ST_IDLE;
            end
            else
                state_next = ST_EMIT;
        end
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted beat did not enter execute");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |-> stat.out_free)
        else $error("result loaded over a pending result");

endmodule

### design/tcw_dpath.sv
module tcw_dpath import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_cmd_t               ctl,
    output ctrl_stat_t              stat,
    input  logic [CMD_W-1:0]        item_command,
    input  logic [CHAR_W-1:0]       item_char_code,
    input  logic signed [OFS_W-1:0] item_move_dx,
    input  logic signed [OFS_W-1:0] item_move_dy,
    input  logic [IDX_W-1:0]        item_cell_index,
    input  logic [CELL_W-1:0]       item_cell_data,
    input  logic                    result_ready,
    output logic                    result_valid,
    output logic [CELL_W-1:0]       read_value,
    output logic [COL_W-1:0]        out_text_col,
    output logic [ROW_W-1:0]        out_text_row,
    output logic [COL_W-1:0]        out_pointer_col,
    output logic [ROW_W-1:0]        out_pointer_row,
    output logic                    screen_cleared
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int AW     = $clog2(CELLS);
    localparam int CW     = $clog2(CELLS + 1);
    localparam int HOST_W = IDX_W + 1;
    localparam int PCOL_RST = (PTR_COL_HOME < COLUMNS) ? PTR_COL_HOME : COLUMNS - 1;
    localparam int PROW_RST = (PTR_ROW_HOME < ROWS) ? PTR_ROW_HOME : ROWS - 1;

    logic [CELL_W-1:0] mem [CELLS];

    // captured item
    cmd_code_t               cmd_reg;
    logic [CHAR_W-1:0]       char_reg;
    logic signed [OFS_W-1:0] dx_reg;
    logic signed [OFS_W-1:0] dy_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [CELL_W-1:0]       data_reg;

    logic [CELL_W-1:0] rdata_reg;
    logic [AW-1:0]     addr_reg;

    logic [COL_W-1:0] text_col_reg, text_col_next;
    logic [ROW_W-1:0] text_row_reg, text_row_next;
    logic [COL_W-1:0] ptr_col_reg, ptr_col_next;
    logic [ROW_W-1:0] ptr_row_reg, ptr_row_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             cleared_reg, cleared_next;
    logic             valid_reg, valid_next;

    logic [CELL_W-1:0] rv_reg;
    logic [COL_W-1:0]  otc_reg;
    logic [ROW_W-1:0]  otr_reg;
    logic [COL_W-1:0]  opc_reg;
    logic [ROW_W-1:0]  opr_reg;
    logic              osc_reg;

    logic [AW-1:0]     text_addr, ptr_addr, item_addr, sweep_addr, rd_addr, wr_addr;
    logic [HOST_W-1:0] item_host_ext, reg_host_ext;
    logic              host_ok;
    logic [CELL_W-1:0] wr_data, read_val;
    logic [COL_W-1:0]  put_col, mv_col, mv_row7;
    logic [ROW_W-1:0]  put_row;
    logic              need_clear, put_write;

    assign text_addr     = AW'(int'(text_row_reg) * COLUMNS) + AW'(text_col_reg);
    assign ptr_addr      = AW'(int'(ptr_row_reg) * COLUMNS) + AW'(ptr_col_reg);
    assign item_host_ext = {1'b0, item_cell_index};
    assign reg_host_ext  = {1'b0, idx_reg};
    assign host_ok       = reg_host_ext < HOST_W'(CELLS);
    assign sweep_addr    = cnt_reg[AW-1:0];

    always_comb
    begin
        case (cmd_code_t'(item_command))
            CMD_PUT:  item_addr = text_addr;
            CMD_MOVE: item_addr = ptr_addr;
            default:  item_addr = item_host_ext[AW-1:0];
        endcase
        case (ctl.rd_sel)
            ADDR_ITEM: rd_addr = item_addr;
            ADDR_PTR:  rd_addr = ptr_addr;
            default:   rd_addr = sweep_addr;
        endcase
    end

    always_comb
    begin
        case (ctl.wr_op)
            WR_PUT:
            begin
                wr_addr = addr_reg;
                wr_data = {rdata_reg[15:8], char_reg};
            end
            WR_SWAP:
            begin
                wr_addr = addr_reg;
                wr_data = {rdata_reg[11:8], rdata_reg[15:12], rdata_reg[7:0]};
            end
            WR_BLANK:
            begin
                wr_addr = addr_reg;
                wr_data = {rdata_reg[15:8], BLANK};
            end
            WR_HOST:
            begin
                wr_addr = reg_host_ext[AW-1:0];
                wr_data = data_reg;
            end
            default:
            begin
                wr_addr = sweep_addr;
                wr_data = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[wr_addr] <= wr_data;
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
            addr_reg  <= rd_addr;
        end
    end

    // text cursor after a put
    always_comb
    begin
        logic [COL_W:0] col_inc;
        logic           row_step;
        logic [COL_W-1:0] nc;
        col_inc  = {1'b0, text_col_reg} + 8'd1;
        row_step = 1'b0;
        nc       = text_col_reg;
        if (char_reg != '0)
        begin
            if (char_reg == NEWLINE || col_inc == 8'(COLUMNS))
            begin
                nc       = '0;
                row_step = 1'b1;
            end
            else
                nc = col_inc[COL_W-1:0];
        end
        need_clear = row_step && (text_row_reg == ROW_W'(ROWS - 1));
        put_write  = (char_reg != '0) && (char_reg != NEWLINE);
        put_col    = need_clear ? '0 : nc;
        put_row    = need_clear ? '0 : text_row_reg + ROW_W'(row_step);
    end

    assign mv_col  = move_axis(ptr_col_reg, dx_reg, 8'(COLUMNS));
    assign mv_row7 = move_axis({2'b00, ptr_row_reg}, dy_reg, 8'(ROWS));

    assign read_val = (cmd_reg == CMD_READ && host_ok) ? rdata_reg : '0;

    always_comb
    begin
        text_col_next = ctl.text_adv ? put_col : text_col_reg;
        text_row_next = ctl.text_adv ? put_row : text_row_reg;
        ptr_col_next  = ctl.ptr_move ? mv_col : ptr_col_reg;
        ptr_row_next  = ctl.ptr_move ? mv_row7[ROW_W-1:0] : ptr_row_reg;

        if (ctl.sweep_clr)
            cnt_next = '0;
        else if (ctl.sweep_inc)
            cnt_next = cnt_reg + CW'(1);
        else
            cnt_next = cnt_reg;

        if (ctl.capture)
            cleared_next = 1'b0;
        else if (ctl.mark_clear)
            cleared_next = 1'b1;
        else
            cleared_next = cleared_reg;

        if (ctl.load_out)
            valid_next = 1'b1;
        else if (result_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_col_reg <= '0;
            text_row_reg <= '0;
            ptr_col_reg  <= COL_W'(PCOL_RST);
            ptr_row_reg  <= ROW_W'(PROW_RST);
            cnt_reg      <= '0;
            cleared_reg  <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            text_col_reg <= text_col_next;
            text_row_reg <= text_row_next;
            ptr_col_reg  <= ptr_col_next;
            ptr_row_reg  <= ptr_row_next;
            cnt_reg      <= cnt_next;
            cleared_reg  <= cleared_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= cmd_code_t'(item_command);
            char_reg <= item_char_code;
            dx_reg   <= item_move_dx;
            dy_reg   <= item_move_dy;
            idx_reg  <= item_cell_index;
            data_reg <= item_cell_data;
        end
        if (ctl.load_out)
        begin
            rv_reg  <= read_val;
            otc_reg <= text_col_next;
            otr_reg <= text_row_next;
            opc_reg <= ptr_col_next;
            opr_reg <= ptr_row_next;
            osc_reg <= cleared_next;
        end
    end

    assign stat.command    = cmd_reg;
    assign stat.put_write  = put_write;
    assign stat.need_clear = need_clear;
    assign stat.host_ok    = host_ok;
    assign stat.sweep_last = cnt_reg == CW'(CELLS - 1);
    assign stat.sweep_full = cnt_reg == CW'(CELLS);
    assign stat.out_free   = !valid_reg || result_ready;

    assign result_valid    = valid_reg;
    assign read_value      = rv_reg;
    assign out_text_col    = otc_reg;
    assign out_text_row    = otr_reg;
    assign out_pointer_col = opc_reg;
    assign out_pointer_row = opr_reg;
    assign screen_cleared  = osc_reg;

    a_text_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(text_col_reg) < COLUMNS) && (int'(text_row_reg) < ROWS))
        else $error("text cursor off screen");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(ptr_col_reg) < COLUMNS) && (int'(ptr_row_reg) < ROWS))
        else $error("pointer off screen");

    a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && osc_reg) |-> (otc_reg == '0 && otr_reg == '0))
        else $error("screen clear without cursor home");

endmodule

### design/text_console_writer.sv
// Text-mode console of COLUMNS x ROWS cells (attribute high byte, character low
// byte) kept in a single on-chip memory with one read and one write port. After
// reset the block zeroes the memory, one cell per cycle, and takes no command
// until every cell is zeroed. Commands are handled one at a time and each gives
// one result beat; a put character is a read-modify-write of the cursor cell and
// a pointer move is two read-modify-write swaps. A put that runs past the last
// row blanks every character through a pipelined read-modify-write walk of the
// memory. A new command is taken while the previous result still waits in the
// output register.
module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic  clk,
    input  logic  rst_n,
    tcw_cmd_if.sink   cmd,
    tcw_res_if.source res
);

    ctrl_cmd_t  ctl;
    ctrl_stat_t stat;

    tcw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (cmd.valid),
        .item_ready (cmd.ready),
        .stat       (stat),
        .ctl        (ctl)
    );

    tcw_dpath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .stat            (stat),
        .item_command    (cmd.command),
        .item_char_code  (cmd.char_code),
        .item_move_dx    (cmd.move_dx),
        .item_move_dy    (cmd.move_dy),
        .item_cell_index (cmd.cell_index),
        .item_cell_data  (cmd.cell_data),
        .result_ready    (res.ready),
        .result_valid    (res.valid),
        .read_value      (res.read_value),
        .out_text_col    (res.out_text_col),
        .out_text_row    (res.out_text_row),
        .out_pointer_col (res.out_pointer_col),
        .out_pointer_row (res.out_pointer_row),
        .screen_cleared  (res.screen_cleared)
    );

endmodule

### sim/tb_text_console_writer.sv
`timescale 1ns / 100ps

module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int SCR_COLS    = 80;
    localparam int SCR_ROWS    = 25;
    localparam int SCR_CELLS   = SCR_COLS * SCR_ROWS;
    localparam int QUIET_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        cmd_code_t          command;
        logic [CHAR_W-1:0]  char_code;
        logic [OFS_W-1:0]   move_dx;
        logic [OFS_W-1:0]   move_dy;
        logic [IDX_W-1:0]   cell_index;
        logic [CELL_W-1:0]  cell_data;
    } console_cmd_t;

    typedef struct {
        logic [CELL_W-1:0]  read_value;
        logic [COL_W-1:0]   text_col;
        logic [ROW_W-1:0]   text_row;
        logic [COL_W-1:0]   ptr_col;
        logic [ROW_W-1:0]   ptr_row;
        logic               cleared;
    } console_view_t;

    logic clk;
    logic rst_n;

    tcw_cmd_if cmd ();
    tcw_res_if res ();

    text_console_writer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .res   (res.source)
    );

    // shadow of the console
    logic [CELL_W-1:0] screen_shadow [SCR_CELLS];
    int                cursor_col;
    int                cursor_row;
    int                mouse_col;
    int                mouse_row;

    console_view_t     pending_views[$];
    int                error_count;
    int                quiet_cycles;
    bit                tx_idle;
    bit                rx_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void toggle_mouse_slot();
        int a;
        a = mouse_row * SCR_COLS + mouse_col;
        screen_shadow[a] = {screen_shadow[a][11:8], screen_shadow[a][15:12],
                            screen_shadow[a][7:0]};
    endfunction

    // 8-bit wrapping add, then clamp onto the screen
    function automatic int clamp_axis(int pos, logic [OFS_W-1:0] off, int lim);
        logic [7:0] s8;
        int         s;
        s8 = pos[7:0] + off;
        s  = int'($signed(s8));
        if (s >= lim)
            s = lim - 1;
        if (s < 0)
            s = 0;
        return s;
    endfunction

    function automatic void reset_shadow();
        foreach (screen_shadow[i])
            screen_shadow[i] = '0;
        cursor_col = 0;
        cursor_row = 0;
        mouse_col  = PTR_COL_HOME;
        mouse_row  = PTR_ROW_HOME;
        toggle_mouse_slot();
    endfunction

    function automatic console_view_t predict_console(console_cmd_t c);
        console_view_t v;
        int            a;
        v.read_value = '0;
        v.cleared    = 1'b0;
        case (c.command)
            CMD_PUT:
            begin
                if (c.char_code != '0)
                begin
                    if (c.char_code == NEWLINE)
                    begin
                        cursor_col = 0;
                        cursor_row++;
                    end
                    else
                    begin
                        a = cursor_row * SCR_COLS + cursor_col;
                        screen_shadow[a] = {screen_shadow[a][15:8], c.char_code};
                        cursor_col++;
                    end
                    if (cursor_col >= SCR_COLS)
                    begin
                        cursor_col = 0;
                        cursor_row++;
                    end
                    if (cursor_row >= SCR_ROWS)
                    begin
                        foreach (screen_shadow[i])
                            screen_shadow[i][7:0] = BLANK;
                        cursor_col = 0;
                        cursor_row = 0;
                        v.cleared  = 1'b1;
                    end
                end
            end
            CMD_MOVE:
            begin
                toggle_mouse_slot();
                mouse_col = clamp_axis(mouse_col, c.move_dx, SCR_COLS);
                mouse_row = clamp_axis(mouse_row, c.move_dy, SCR_ROWS);
                toggle_mouse_slot();
            end
            CMD_READ:
            begin
                if (c.cell_index < SCR_CELLS)
                    v.read_value = screen_shadow[c.cell_index];
            end
            default:
            begin
                if (c.cell_index < SCR_CELLS)
                    screen_shadow[c.cell_index] = c.cell_data;
            end
        endcase
        v.text_col = cursor_col[COL_W-1:0];
        v.text_row = cursor_row[ROW_W-1:0];
        v.ptr_col  = mouse_col[COL_W-1:0];
        v.ptr_row  = mouse_row[ROW_W-1:0];
        return v;
    endfunction

    // every field random; callers override what matters
    function automatic console_cmd_t noise_cmd(cmd_code_t op);
        console_cmd_t c;
        c.command    = op;
        c.char_code  = 8'($urandom_range(0, 255));
        c.move_dx    = 8'($urandom_range(0, 255));
        c.move_dy    = 8'($urandom_range(0, 255));
        c.cell_index = 11'($urandom_range(0, 2047));
        c.cell_data  = 16'($urandom_range(0, 65535));
        return c;
    endfunction

    function automatic console_cmd_t make_cmd(cmd_code_t op, int arg_a, int arg_b);
        console_cmd_t c;
        c = noise_cmd(op);
        case (op)
            CMD_PUT:   c.char_code = arg_a[7:0];
            CMD_MOVE:
            begin
                c.move_dx = arg_a[7:0];
                c.move_dy = arg_b[7:0];
            end
            CMD_READ:  c.cell_index = arg_a[10:0];
            default:
            begin
                c.cell_index = arg_a[10:0];
                c.cell_data  = arg_b[15:0];
            end
        endcase
        return c;
    endfunction

    function automatic console_cmd_t random_cmd(int newline_pct);
        console_cmd_t c;
        int           r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            c = noise_cmd(CMD_PUT);
            r = $urandom_range(0, 99);
            if (r < newline_pct)
                c.char_code = NEWLINE;
            else if (r < newline_pct + 3)
                c.char_code = '0;
            else
                c.char_code = 8'($urandom_range(1, 255));
        end
        else if (r < 70)
        begin
            c = noise_cmd(CMD_MOVE);
            // half the moves take small steps so the pointer wanders inside the screen
            if ($urandom_range(0, 1))
            begin
                c.move_dx = 8'($urandom_range(0, 16) - 8);
                c.move_dy = 8'($urandom_range(0, 6) - 3);
            end
        end
        else
        begin
            c = noise_cmd(r < 85 ? CMD_READ : CMD_WRITE);
            r = $urandom_range(0, 99);
            if (r < 10)
                c.cell_index = 11'($urandom_range(SCR_CELLS, 2047));
            else if (r < 40)
                c.cell_index = 11'(cursor_row * SCR_COLS + $urandom_range(0, SCR_COLS - 1));
            else if (r < 55)
                c.cell_index = 11'(mouse_row * SCR_COLS + mouse_col);
            else
                c.cell_index = 11'($urandom_range(0, SCR_CELLS - 1));
        end
        return c;
    endfunction

    task automatic send_cmd(console_cmd_t c);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.command    <= c.command;
        cmd.char_code  <= c.char_code;
        cmd.move_dx    <= c.move_dx;
        cmd.move_dy    <= c.move_dy;
        cmd.cell_index <= c.cell_index;
        cmd.cell_data  <= c.cell_data;
        do
            @(posedge clk);
        while (!cmd.ready);
        pending_views.push_back(predict_console(c));
    endtask

    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name,
                         exp_v, got_v);
        end
    endfunction

    // result side: random stalls, compare each beat with the oldest prediction
    initial
    begin : result_check
        console_view_t want;
        int            stall;
        res.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res.valid);
            if (pending_views.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result beat with nothing pending", $realtime);
            end
            else
            begin
                want = pending_views.pop_front();
                check_field("read_value", want.read_value, res.read_value);
                check_field("out_text_col", 16'(want.text_col), 16'(res.out_text_col));
                check_field("out_text_row", 16'(want.text_row), 16'(res.out_text_row));
                check_field("out_pointer_col", 16'(want.ptr_col),
                            16'(res.out_pointer_col));
                check_field("out_pointer_row", 16'(want.ptr_row),
                            16'(res.out_pointer_row));
                check_field("screen_cleared", 16'(want.cleared), 16'(res.screen_cleared));
            end
        end
    end

    // long quiet stretches cover the zeroing pass and a full-screen blank
    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_reset_state();
        send_cmd(make_cmd(CMD_READ, 0, 0));
        send_cmd(make_cmd(CMD_READ, PTR_ROW_HOME * SCR_COLS + PTR_COL_HOME, 0));
        send_cmd(make_cmd(CMD_READ, SCR_CELLS - 1, 0));
        send_cmd(make_cmd(CMD_READ, 2047, 0));
    endtask

    task automatic test_cell_access();
        send_cmd(make_cmd(CMD_WRITE, 0, 16'hFFFF));
        send_cmd(make_cmd(CMD_WRITE, SCR_CELLS - 1, 16'hA55A));
        send_cmd(make_cmd(CMD_WRITE, 2047, 16'hFFFF));
        send_cmd(make_cmd(CMD_READ, 0, 0));
        send_cmd(make_cmd(CMD_READ, SCR_CELLS - 1, 0));
        send_cmd(make_cmd(CMD_READ, SCR_CELLS, 0));
    endtask

    task automatic test_put_chars();
        send_cmd(make_cmd(CMD_PUT, 0, 0));
        send_cmd(make_cmd(CMD_PUT, 255, 0));
        send_cmd(make_cmd(CMD_PUT, 1, 0));
        send_cmd(make_cmd(CMD_PUT, NEWLINE, 0));
        send_cmd(make_cmd(CMD_READ, 0, 0));
    endtask

    task automatic test_pointer_moves();
        send_cmd(make_cmd(CMD_MOVE, 127, 127));
        send_cmd(make_cmd(CMD_MOVE, -128, -128));
        send_cmd(make_cmd(CMD_MOVE, -1, -1));
        send_cmd(make_cmd(CMD_MOVE, 79, 24));
        send_cmd(make_cmd(CMD_MOVE, 0, 0));
        send_cmd(make_cmd(CMD_READ, mouse_row * SCR_COLS + mouse_col, 0));
    endtask

    // idle_mode: 0 none, 1 always, 2 switching on and off
    task automatic test_random_traffic(int n_items, int newline_pct, int idle_mode);
        tx_idle = (idle_mode != 0);
        rx_idle = (idle_mode != 0);
        for (int k = 0; k < n_items; k++)
        begin
            if (idle_mode == 2 && $urandom_range(0, 19) == 0)
                tx_idle = ~tx_idle;
            if (idle_mode == 2 && $urandom_range(0, 19) == 0)
                rx_idle = ~rx_idle;
            send_cmd(random_cmd(newline_pct));
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cmd.valid      <= 1'b0;
        cmd.command    <= CMD_PUT;
        cmd.char_code  <= '0;
        cmd.move_dx    <= '0;
        cmd.move_dy    <= '0;
        cmd.cell_index <= '0;
        cmd.cell_data  <= '0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        reset_shadow();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_cell_access();
        test_put_chars();
        test_pointer_moves();
        // long lines to wrap at the right edge
        test_random_traffic(250, 2, 1);
        // newline heavy, runs off the bottom several times
        test_random_traffic(200, 60, 0);
        test_random_traffic(300, 12, 2);

        cmd.valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
